>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NLU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define NLU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/nlu_pkg.sv
// ----------------------------------------------------------------------------
// nlu_pkg
// types and constants shared by the numeric literal converter
// ----------------------------------------------------------------------------
package nlu_pkg;

	// base codes carried with each character
	localparam logic [1:0] ACT_BIN = 2'd0;
	localparam logic [1:0] ACT_DEC = 2'd1;
	localparam logic [1:0] ACT_HEX = 2'd2;

	// separators that are skipped in every base
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHAR_BACKTICK   = 8'h60;
	localparam logic [7:0] CHAR_ZERO       = 8'h30;
	localparam logic [7:0] CHAR_NINE       = 8'h39;
	localparam logic [7:0] CHAR_LC_A       = 8'h61;
	localparam logic [7:0] CHAR_LC_F       = 8'h66;
	localparam logic [7:0] CHAR_UC_A       = 8'h41;
	localparam logic [7:0] CHAR_UC_F       = 8'h46;

	// digit limits for binary and hex
	localparam logic [6:0] BIN_LIMIT = 7'd64;
	localparam logic [6:0] HEX_LIMIT = 7'd16;

	// largest accumulator that can still be multiplied by ten
	localparam logic [63:0] DEC_MUL_MAX = 64'h1999_9999_9999_9999;

	typedef struct packed {
		logic [7:0] char_code;
		logic [1:0] action;
		logic       last_char;
	} char_item_t;

	typedef struct packed {
		logic [63:0] value;
		logic        overflow;
	} res_item_t;

	typedef struct packed {
		logic [63:0] accumulator;
		logic [6:0]  digit_count;
		logic        seen_nonzero;
		logic        overflowed;
	} conv_state_t;

endpackage

>>> hw/rtl/nlu_step.sv
// ----------------------------------------------------------------------------
// nlu_step
// one-character update of the conversion state and the result it would give
// ----------------------------------------------------------------------------
module nlu_step (
	input  nlu_pkg::char_item_t  item,
	input  nlu_pkg::conv_state_t cur,
	output nlu_pkg::conv_state_t nxt,
	output nlu_pkg::res_item_t   res
);

	logic        is_sep;
	logic [7:0]  c;
	logic        is_digit;
	logic        is_lower;
	logic        is_upper;
	logic [3:0]  hex_nib;
	logic [63:0] times_ten;
	logic [64:0] dec_sum;

	assign c        = item.char_code;
	assign is_sep   = (c == nlu_pkg::CHAR_UNDERSCORE) || (c == nlu_pkg::CHAR_BACKTICK);
	assign is_digit = (c >= nlu_pkg::CHAR_ZERO) && (c <= nlu_pkg::CHAR_NINE);
	assign is_lower = (c >= nlu_pkg::CHAR_LC_A) && (c <= nlu_pkg::CHAR_LC_F);
	assign is_upper = (c >= nlu_pkg::CHAR_UC_A) && (c <= nlu_pkg::CHAR_UC_F);
	// letters a-f / A-F have low nibble 1..6, add 9 for 10..15
	assign hex_nib  = is_digit ? c[3:0] : (c[3:0] + 4'd9);

	// acc*10 as acc*8 + acc*2, only used when acc fits
	assign times_ten = {cur.accumulator[60:0], 3'b000} + {cur.accumulator[62:0], 1'b0};
	assign dec_sum   = {1'b0, times_ten} + {61'd0, c[3:0]};

	always_comb begin
		nxt = cur;
		if (!cur.overflowed && !is_sep) begin
			unique case (item.action)
				nlu_pkg::ACT_BIN: begin
					if (cur.digit_count >= nlu_pkg::BIN_LIMIT) begin
						nxt.overflowed = 1'b1;
					end else begin
						nxt.digit_count = cur.digit_count + 7'd1;
						nxt.accumulator = {cur.accumulator[62:0], c[0]};
					end
				end
				nlu_pkg::ACT_DEC: begin
					// leading zeros are dropped
					if (!(c == nlu_pkg::CHAR_ZERO && !cur.seen_nonzero)) begin
						nxt.seen_nonzero = 1'b1;
						if (cur.accumulator > nlu_pkg::DEC_MUL_MAX) begin
							nxt.overflowed = 1'b1;
						end else begin
							nxt.accumulator = dec_sum[63:0];
							nxt.overflowed  = dec_sum[64];
						end
					end
				end
				nlu_pkg::ACT_HEX: begin
					if (cur.digit_count >= nlu_pkg::HEX_LIMIT) begin
						nxt.overflowed = 1'b1;
					end else begin
						nxt.digit_count = cur.digit_count + 7'd1;
						// non-hex characters count but leave the value alone
						if (is_digit || is_lower || is_upper) begin
							nxt.accumulator = {cur.accumulator[59:0], hex_nib};
						end
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

	assign res.value    = nxt.overflowed ? 64'd0 : nxt.accumulator;
	assign res.overflow = nxt.overflowed;

endmodule

>>> hw/rtl/numeric_literal_to_u64_unit.sv
// ----------------------------------------------------------------------------
// numeric_literal_to_u64_unit
// path: a last item goes from the input register to the result register
// throughput: one item per cycle unless a last item waits on the result slot
// reset: arst_n clears the conversion state and all valid flags at once
// converts a binary, decimal or hex literal, one character per item, to u64
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module numeric_literal_to_u64_unit (
	input  logic                clk,
	input  logic                arst_n,
	// character items
	input  logic                char_valid,
	output logic                char_stall,
	input  nlu_pkg::char_item_t char_data,
	// result items
	output logic                res_valid,
	input  logic                res_stall,
	output nlu_pkg::res_item_t  res_data
);

	// input register
	logic                 valid_s1;
	nlu_pkg::char_item_t  item_s1;

	// conversion state, shared across the characters of one literal
	nlu_pkg::conv_state_t state_q;
	nlu_pkg::conv_state_t state_nxt;
	nlu_pkg::res_item_t   res_nxt;

	// result register
	logic                 res_valid_q;
	nlu_pkg::res_item_t   res_q;

	logic                 res_free;
	logic                 s1_go;
	logic                 char_take;

	// combinational step on the registered character
	nlu_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// result slot is free when empty or being drained this cycle
	assign res_free  = !res_valid_q || !res_stall;
	// a non-last character never waits; a last one needs the result slot
	assign s1_go     = valid_s1 && (!item_s1.last_char || res_free);
	assign char_stall = valid_s1 && !s1_go;
	assign char_take = char_valid && !char_stall;

	// input register: reload whenever the held item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_take) begin
			item_s1 <= char_data;
		end
	end

	// state update, cleared after the last character of a literal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_go) begin
			state_q <= item_s1.last_char ? '0 : state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && item_s1.last_char) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.last_char) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// state is back to empty right after a literal ends
	`NLU_ASSERT_NEXT(a_clear_after_last, s1_go && item_s1.last_char, state_q == '0)
	// an overflowed result always carries a zero value
	`NLU_ASSERT_NOW(a_ovf_zero, res_valid_q && res_q.overflow, res_q.value == 64'd0)
	// digit count never passes the binary limit
	`NLU_ASSERT_NOW(a_count_range, 1'b1, state_q.digit_count <= nlu_pkg::BIN_LIMIT)
	// input only stalls behind a last character waiting on a full result slot
	`NLU_ASSERT_NOW(a_stall_cause, char_stall,
		valid_s1 && item_s1.last_char && res_valid_q && res_stall)

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for numeric_literal_to_u64_unit: a short directed table
// of literals, then random binary, decimal and hex literals plus noise, with
// random gaps on the character side and random stalls on the result side;
// every result is compared against a typed row or a local conversion model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	// base code with no name in the package, the block ignores it
	localparam logic [1:0]  ACT_UNUSED  = 2'd3;
	localparam logic [63:0] U64_MAX     = '1;
	localparam logic [63:0] DEC_RADIX   = 64'd10;
	localparam logic [63:0] MUL_LIMIT   = U64_MAX / DEC_RADIX;
	localparam int          RAND_CHARS  = 1350;
	localparam int          DRAIN       = 10;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          N_DIR       = 23;

	// one directed row: the item, and an expectation where it is obvious
	typedef struct packed {
		nlu_pkg::char_item_t item;
		logic                typed;
		nlu_pkg::res_item_t  want;
	} dir_row_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                char_valid = 1'b0;
	logic                char_stall;
	nlu_pkg::char_item_t char_data  = '0;
	logic                res_valid;
	logic                res_stall  = 1'b0;
	nlu_pkg::res_item_t  res_data;

	// conversion model state
	logic [63:0] lit_acc      = '0;
	logic [6:0]  lit_count    = '0;
	logic        lit_nonzero  = 1'b0;
	logic        lit_overflow = 1'b0;

	nlu_pkg::res_item_t lit_expect_q[$];
	logic [7:0]         lit_text[$];
	int                 mismatches  = 0;
	int                 chars_used  = 0;
	int                 stall_left  = 0;
	int unsigned        cycle_count = 0;
	bit                 calm        = 1'b0;

	// directed literals: empty, each base, separators, extremes, mixed bases
	dir_row_t dir_rows [N_DIR] = '{
		'{'{nlu_pkg::CHAR_UNDERSCORE, nlu_pkg::ACT_BIN, 1'b1}, 1'b1, '{64'd0, 1'b0}},
		'{'{"1", nlu_pkg::ACT_BIN, 1'b0}, 1'b0, '0},
		'{'{"0", nlu_pkg::ACT_BIN, 1'b0}, 1'b0, '0},
		'{'{"1", nlu_pkg::ACT_BIN, 1'b1}, 1'b1, '{64'd5, 1'b0}},
		'{'{"0", nlu_pkg::ACT_DEC, 1'b0}, 1'b0, '0},
		'{'{"0", nlu_pkg::ACT_DEC, 1'b0}, 1'b0, '0},
		'{'{"4", nlu_pkg::ACT_DEC, 1'b0}, 1'b0, '0},
		'{'{nlu_pkg::CHAR_UNDERSCORE, nlu_pkg::ACT_DEC, 1'b0}, 1'b0, '0},
		'{'{"2", nlu_pkg::ACT_DEC, 1'b1}, 1'b1, '{64'd42, 1'b0}},
		'{'{"F", nlu_pkg::ACT_HEX, 1'b0}, 1'b0, '0},
		'{'{nlu_pkg::CHAR_BACKTICK, nlu_pkg::ACT_HEX, 1'b0}, 1'b0, '0},
		'{'{"a", nlu_pkg::ACT_HEX, 1'b1}, 1'b1, '{64'hFA, 1'b0}},
		'{'{"G", nlu_pkg::ACT_HEX, 1'b0}, 1'b0, '0},
		'{'{"1", nlu_pkg::ACT_HEX, 1'b1}, 1'b0, '0},
		'{'{8'hFF, ACT_UNUSED, 1'b1}, 1'b1, '{64'd0, 1'b0}},
		'{'{8'h00, nlu_pkg::ACT_BIN, 1'b1}, 1'b1, '{64'd0, 1'b0}},
		'{'{8'hFF, nlu_pkg::ACT_BIN, 1'b1}, 1'b1, '{64'd1, 1'b0}},
		'{'{8'h00, nlu_pkg::ACT_DEC, 1'b0}, 1'b0, '0},
		'{'{8'hFF, nlu_pkg::ACT_DEC, 1'b1}, 1'b0, '0},
		'{'{"1", nlu_pkg::ACT_DEC, 1'b0}, 1'b0, '0},
		'{'{"A", nlu_pkg::ACT_HEX, 1'b1}, 1'b0, '0},
		'{'{"7", ACT_UNUSED, 1'b0}, 1'b0, '0},
		'{'{"3", nlu_pkg::ACT_DEC, 1'b1}, 1'b0, '0}
	};

	numeric_literal_to_u64_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// gap length for either side: mostly none, often short, rarely long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// advance the conversion model by one item; returns 1 when a result is due
	function automatic bit convert_char(input nlu_pkg::char_item_t it,
		output nlu_pkg::res_item_t res);
		logic [7:0]  ch;
		logic [63:0] dig;
		ch  = it.char_code;
		dig = '0;
		res = '0;
		// separators and anything after an overflow leave the state alone
		if (!lit_overflow && ch != nlu_pkg::CHAR_UNDERSCORE
				&& ch != nlu_pkg::CHAR_BACKTICK) begin
			case (it.action)
				nlu_pkg::ACT_BIN: begin
					if (lit_count >= nlu_pkg::BIN_LIMIT) begin
						lit_overflow = 1'b1;
					end else begin
						// any byte is taken, only its low bit matters
						lit_count++;
						lit_acc = {lit_acc[62:0], ch[0]};
					end
				end
				nlu_pkg::ACT_DEC: begin
					// leading zeros are dropped and not counted
					if (!(ch == nlu_pkg::CHAR_ZERO && !lit_nonzero)) begin
						lit_nonzero = 1'b1;
						dig = 64'(ch[3:0]);
						if (lit_acc > MUL_LIMIT) begin
							lit_overflow = 1'b1;
						end else begin
							lit_acc = lit_acc * DEC_RADIX;
							if (lit_acc > U64_MAX - dig) lit_overflow = 1'b1;
							else lit_acc = lit_acc + dig;
						end
					end
				end
				nlu_pkg::ACT_HEX: begin
					if (lit_count >= nlu_pkg::HEX_LIMIT) begin
						lit_overflow = 1'b1;
					end else begin
						// non-hex bytes use up a digit slot but add nothing
						lit_count++;
						if (ch >= nlu_pkg::CHAR_LC_A && ch <= nlu_pkg::CHAR_LC_F)
							lit_acc = {lit_acc[59:0], 4'h0}
								+ 64'(ch - nlu_pkg::CHAR_LC_A) + 64'd10;
						else if (ch >= nlu_pkg::CHAR_UC_A && ch <= nlu_pkg::CHAR_UC_F)
							lit_acc = {lit_acc[59:0], 4'h0}
								+ 64'(ch - nlu_pkg::CHAR_UC_A) + 64'd10;
						else if (ch >= nlu_pkg::CHAR_ZERO && ch <= nlu_pkg::CHAR_NINE)
							lit_acc = {lit_acc[59:0], 4'h0}
								+ 64'(ch - nlu_pkg::CHAR_ZERO);
					end
				end
				default: ;
			endcase
		end
		if (!it.last_char) return 1'b0;
		res.value    = lit_overflow ? 64'd0 : lit_acc;
		res.overflow = lit_overflow;
		lit_acc      = '0;
		lit_count    = '0;
		lit_nonzero  = 1'b0;
		lit_overflow = 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		// keep the log short if everything goes wrong
		if (mismatches <= 100) $display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// present one item, hold it until taken, then book its expected result
	task automatic send_char(input nlu_pkg::char_item_t it, input logic typed,
		input nlu_pkg::res_item_t typed_res);
		int                 gap;
		nlu_pkg::res_item_t res;
		gap = idle_len();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= it;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		if (convert_char(it, res)) lit_expect_q.push_back(typed ? typed_res : res);
		// separators and the unused base do not count as real work
		if (it.char_code != nlu_pkg::CHAR_UNDERSCORE
				&& it.char_code != nlu_pkg::CHAR_BACKTICK
				&& it.action != ACT_UNUSED)
			chars_used++;
	endtask

	// send the queued characters as one literal, sprinkling separators in
	task automatic send_literal(input logic [1:0] act);
		nlu_pkg::char_item_t it;
		for (int i = 0; i < lit_text.size(); i++) begin
			if ($urandom_range(0, 99) < 8) begin
				it = '{($urandom_range(0, 1) ? nlu_pkg::CHAR_UNDERSCORE
					: nlu_pkg::CHAR_BACKTICK), act, 1'b0};
				send_char(it, 1'b0, '0);
			end
			it = '{lit_text[i], act, (i == lit_text.size() - 1)};
			send_char(it, 1'b0, '0);
		end
		lit_text.delete();
	endtask

	// result side: random stall bursts, each followed by an open gap
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall  <= 1'b0;
			stall_left = idle_len();
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		nlu_pkg::res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (lit_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %h overflow %b",
					res_data.value, res_data.overflow));
			end else begin
				want = lit_expect_q.pop_front();
				if (res_data.value !== want.value)
					report_mismatch($sformatf("value got %h want %h",
						res_data.value, want.value));
				if (res_data.overflow !== want.overflow)
					report_mismatch($sformatf("overflow got %b want %b",
						res_data.overflow, want.overflow));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		nlu_pkg::char_item_t it;
		int                  kind;
		int                  len;
		int                  r;
		logic [7:0]          ch;
		logic [63:0]         v;
		string               s;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int n = 0; n < N_DIR; n++)
			send_char(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].want);

		// random literals, mostly well formed
		while (chars_used < RAND_CHARS) begin
			// occasionally switch to or from a stretch with no gaps or stalls
			if ($urandom_range(0, 19) == 0) calm = !calm;
			kind = $urandom_range(0, 99);
			if (kind < 25) begin
				// binary, some runs around the 64 digit limit
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 68)
					: $urandom_range(1, 24);
				repeat (len) begin
					if ($urandom_range(0, 29) == 0) ch = 8'($urandom);
					else ch = nlu_pkg::CHAR_ZERO + 8'($urandom_range(0, 1));
					lit_text.push_back(ch);
				end
				send_literal(nlu_pkg::ACT_BIN);
			end else if (kind < 55) begin
				// decimal, with leading zeros and values near the 64-bit top
				r = $urandom_range(0, 99);
				repeat ($urandom_range(0, 3)) lit_text.push_back(nlu_pkg::CHAR_ZERO);
				if (r < 45) begin
					repeat ($urandom_range(1, 19)) begin
						if ($urandom_range(0, 19) == 0) ch = 8'($urandom);
						else ch = nlu_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
						lit_text.push_back(ch);
					end
				end else begin
					if (r < 60) v = U64_MAX - 64'($urandom_range(0, 15));
					else v = {$urandom, $urandom};
					// one digit short of the top, the add step decides
					if (r >= 85) v = MUL_LIMIT;
					s = $sformatf("%0d", v);
					for (int i = 0; i < s.len(); i++) lit_text.push_back(s[i]);
					// an extra digit pushes most values past the range
					if (r >= 70)
						lit_text.push_back(nlu_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
				end
				send_literal(nlu_pkg::ACT_DEC);
			end else if (kind < 88) begin
				// hex, mixed case, some non-hex bytes, some past 16 digits
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 18)
					: $urandom_range(1, 12);
				repeat (len) begin
					r = $urandom_range(0, 23);
					if (r < 10) ch = nlu_pkg::CHAR_ZERO + 8'(r);
					else if (r < 16) ch = nlu_pkg::CHAR_LC_A + 8'(r - 10);
					else if (r < 22) ch = nlu_pkg::CHAR_UC_A + 8'(r - 16);
					else ch = 8'($urandom);
					lit_text.push_back(ch);
				end
				send_literal(nlu_pkg::ACT_HEX);
			end else begin
				// noise: any byte, any base code, bases mixed within a literal
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					it = '{8'($urandom), 2'($urandom), (i == len - 1)};
					send_char(it, 1'b0, '0);
				end
			end
		end
		char_valid <= 1'b0;

		// drain outstanding results, the watchdog covers a hang
		while (lit_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
